[src/assert_macros.svh]
// assertion macros shared by the hazard tracker rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that two conditions never hold together
`define ASSERT_NEVER(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !((a) && (b))) else $error(msg);

`endif

[src/rht_pkg.sv]
// shared types and constants for the raw hazard tracker
// used by rht_ctrl, rht_datapath and pipeline_raw_hazard_tracker
package rht_pkg;

	localparam int NUM_STAGES = 8;
	localparam int STAGE_W    = 3;
	localparam int REG_W      = 5;
	localparam int FUNC_W     = 3;
	localparam int CNT_W      = 32;
	localparam int ADD_W      = 3;
	localparam int NEED_W     = 5;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 136;

	localparam logic [STAGE_W-1:0] STAGE_IF1  = STAGE_W'(0);
	localparam logic [STAGE_W-1:0] STAGE_ID   = STAGE_W'(2);
	localparam logic [STAGE_W-1:0] STAGE_EXE1 = STAGE_W'(3);
	localparam logic [STAGE_W-1:0] STAGE_WB   = STAGE_W'(NUM_STAGES - 1);

	localparam logic [CNT_W-1:0] CYCLE_RESET = CNT_W'(NUM_STAGES - 1);

	localparam logic [FUNC_W-1:0] FUNC_CLOCK = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SRC   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_DEST  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

	typedef struct packed {
		logic load;
		logic exec;
		logic shift;
		logic emit;
	} rht_cmd_t;

	typedef struct packed {
		logic start_shift;
		logic last_shift;
	} rht_status_t;

endpackage

[src/rht_ctrl.sv]
// controller state machine for the raw hazard tracker
// depends on rht_pkg and assert_macros.svh
`include "assert_macros.svh"

module rht_ctrl
	import rht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  rht_status_t status,
	output rht_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_DONE  = 4'b1000
	} rht_state_t;

	rht_state_t state_q;
	rht_state_t state_d;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.load  = s_tvalid && (state_q == ST_IDLE);
		cmd.exec  = (state_q == ST_EXEC);
		cmd.shift = (state_q == ST_SHIFT);
		cmd.emit  = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = status.start_shift ? ST_SHIFT : ST_DONE;
			end
			ST_SHIFT: begin
				if (status.last_shift) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (cmd.emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// shift run only follows execute
	`ASSERT_CLK(a_shift_entry, (state_q == ST_SHIFT) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_SHIFT), "shift state entered from wrong state")
	// a new result appears only out of the done state
	`ASSERT_CLK(a_emit_src, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result raised outside done state")
	`ASSERT_NEVER(a_emit_load, cmd.emit, cmd.load, "emit and load in one cycle")

endmodule

[src/rht_datapath.sv]
// slot shift register, hazard scan and counters of the raw hazard tracker
// depends on rht_pkg and assert_macros.svh
`include "assert_macros.svh"

module rht_datapath
	import rht_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  rht_cmd_t               cmd,
	output rht_status_t            status,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [FUNC_W-1:0]      s_tuser,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	// latched transaction
	logic [FUNC_W-1:0]  func_q;
	logic [REG_W-1:0]   regn_q;
	logic [STAGE_W-1:0] stage_q;
	logic [STAGE_W-1:0] flen_q;

	// pipeline slots
	logic [NUM_STAGES-1:0]   valid_q, valid_d;
	logic [REG_W-1:0]        reg_q [NUM_STAGES];
	logic [REG_W-1:0]        reg_d [NUM_STAGES];
	logic [STAGE_W-1:0]      rdy_q [NUM_STAGES];
	logic [STAGE_W-1:0]      rdy_d [NUM_STAGES];

	logic [CNT_W-1:0] hazard_q [NUM_STAGES];
	logic [CNT_W-1:0] cycle_q;
	logic [CNT_W-1:0] bubble_q;
	logic [CNT_W-1:0] flush_q;

	logic             bubble_mode_q;
	logic [ADD_W-1:0] cnt_q;
	logic [ADD_W-1:0] added_q;
	logic             found_q;

	logic               hit;
	logic [STAGE_W-1:0] hit_idx;
	logic [NEED_W-1:0]  need;
	logic [ADD_W-1:0]   exec_cnt;
	logic               shift_en;
	logic [STAGE_W-1:0] shift_from;
	logic               id_write;

	// nearest producer between exe1 and mem2
	always_comb begin
		hit     = 1'b0;
		hit_idx = STAGE_EXE1;
		for (int i = NUM_STAGES - 2; i >= int'(STAGE_EXE1); i--) begin
			if (valid_q[i] && (reg_q[i] == regn_q)) begin
				hit     = 1'b1;
				hit_idx = STAGE_W'(i);
			end
		end
	end

	always_comb begin
		need = {2'b00, rdy_q[hit_idx]} - {2'b00, hit_idx} - {2'b00, stage_q}
			+ {2'b00, STAGE_ID};
		exec_cnt = '0;
		case (func_q)
			FUNC_SRC: begin
				if (hit && !need[NEED_W-1] && (need != '0)) exec_cnt = need[ADD_W-1:0];
			end
			FUNC_FLUSH: exec_cnt = flen_q;
			default: exec_cnt = '0;
		endcase
	end

	assign status.start_shift = (exec_cnt != '0);
	assign status.last_shift  = (cnt_q == ADD_W'(1));

	assign shift_en   = (cmd.exec && (func_q == FUNC_CLOCK)) || cmd.shift;
	assign shift_from = cmd.shift ? (bubble_mode_q ? STAGE_EXE1 : STAGE_IF1) : stage_q;
	assign id_write   = cmd.exec && (func_q == FUNC_DEST);

	always_comb begin
		valid_d = valid_q;
		reg_d   = reg_q;
		rdy_d   = rdy_q;
		if (shift_en) begin
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (STAGE_W'(i) > shift_from) begin
					valid_d[i] = valid_q[i-1];
					reg_d[i]   = reg_q[i-1];
					rdy_d[i]   = rdy_q[i-1];
				end
			end
			valid_d[shift_from] = 1'b0;
			reg_d[shift_from]   = '0;
			rdy_d[shift_from]   = '0;
		end else if (id_write) begin
			valid_d[STAGE_ID] = 1'b1;
			reg_d[STAGE_ID]   = regn_q;
			rdy_d[STAGE_ID]   = stage_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= s_tuser;
			regn_q  <= s_tdata[4:0];
			stage_q <= s_tdata[7:5];
			flen_q  <= s_tdata[10:8];
		end
		if (cmd.exec) begin
			bubble_mode_q <= (func_q == FUNC_SRC);
			added_q       <= (func_q == FUNC_SRC) ? exec_cnt : '0;
			found_q       <= (func_q == FUNC_SRC) && hit;
		end
		if (cmd.emit) begin
			m_tdata <= {4'b0000, found_q, added_q, hazard_q[stage_q], flush_q,
				bubble_q, cycle_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			cycle_q  <= CYCLE_RESET;
			bubble_q <= '0;
			flush_q  <= '0;
			cnt_q    <= '0;
			for (int i = 0; i < NUM_STAGES; i++) begin
				reg_q[i]    <= '0;
				rdy_q[i]    <= '0;
				hazard_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			reg_q   <= reg_d;
			rdy_q   <= rdy_d;
			if (shift_en) cycle_q <= cycle_q + CNT_W'(1);
			if (cmd.shift && bubble_mode_q) bubble_q <= bubble_q + CNT_W'(1);
			if (cmd.shift && !bubble_mode_q) flush_q <= flush_q + CNT_W'(1);
			if (cmd.exec) begin
				cnt_q <= exec_cnt;
			end else if (cmd.shift) begin
				cnt_q <= cnt_q - ADD_W'(1);
			end
			if (cmd.exec && (func_q == FUNC_SRC) && hit) begin
				hazard_q[hit_idx] <= hazard_q[hit_idx] + CNT_W'(1);
			end
		end
	end

	// a shift step always has a step left to run
	`ASSERT_CLK(a_shift_cnt, cmd.shift |-> (cnt_q != '0), "shift step with empty run counter")
	// a bubble step from the run keeps the slot before exe1 and earlier in place
	`ASSERT_CLK(a_bubble_keep, (cmd.shift && bubble_mode_q) |=> (valid_q[STAGE_ID] == $past(valid_q[STAGE_ID])), "bubble disturbed the id slot")

endmodule

[src/pipeline_raw_hazard_tracker.sv]
// top level of the raw hazard tracker for an 8-stage pipeline
// depends on rht_pkg, rht_ctrl and rht_datapath
//
// one request transaction on the s_ channel gives exactly one result
// transaction on the m_ channel. s_tuser carries the operation code
// (clock, register source, register destination, flush, read counters),
// s_tdata the register number, stage and flush length.
// an accepted request runs an execute state, then one shift step per bubble or
// flushed slot (zero to seven), then a done state that loads the result
// register. a new request can be taken in the cycle after the result is
// loaded; no request is taken while the one ahead of it is still running.
// the result register holds while m_tready is low; the next request is
// still accepted and runs up to its done state, where it waits for the
// register to empty.
// reset empties all slots, clears the hazard, bubble and flush counters
// and sets the cycle counter to seven.
module pipeline_raw_hazard_tracker
	import rht_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// reg_num[4:0], stage[7:5], flush_len[10:8], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// func[2:0]
	input  logic [FUNC_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// cycle_total[31:0], bubble_total[63:32], flush_total[95:64],
	// hazard_total[127:96], bubbles_added[130:128], hazard_found[131], zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	rht_cmd_t    cmd;
	rht_status_t status;

	rht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rht_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata)
	);

endmodule

[dv/pipeline_raw_hazard_tracker_checker.sv]
`timescale 1ns / 1ps
// scoreboard for pipeline_raw_hazard_tracker: watches both stream channels, keeps its
// own copy of the slot pipeline and counters, and compares every result transaction
// depends on rht_pkg
module pipeline_raw_hazard_tracker_checker
	import rht_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [FUNC_W-1:0]      s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     errors,
	output int                     pending
);

	// declared msb first so it lines up with m_tdata from bit 0
	typedef struct packed {
		logic             hazard_found;
		logic [ADD_W-1:0] bubbles_added;
		logic [CNT_W-1:0] hazard_total;
		logic [CNT_W-1:0] flush_total;
		logic [CNT_W-1:0] bubble_total;
		logic [CNT_W-1:0] cycle_total;
	} totals_t;

	logic               slot_live [NUM_STAGES];
	logic [REG_W-1:0]   slot_dst  [NUM_STAGES];
	logic [STAGE_W-1:0] slot_rdy  [NUM_STAGES];
	logic [CNT_W-1:0]   hazard_cnt[NUM_STAGES];
	logic [CNT_W-1:0]   cycle_cnt;
	logic [CNT_W-1:0]   bubble_cnt;
	logic [CNT_W-1:0]   flush_cnt;
	totals_t            expected_totals[$];
	totals_t            seen;
	totals_t            want;
	int                 k;

	function automatic void advance_slots(int from);
		int i;
		cycle_cnt++;
		for (i = NUM_STAGES - 1; i > from; i--) begin
			slot_live[i] = slot_live[i-1];
			slot_dst[i]  = slot_dst[i-1];
			slot_rdy[i]  = slot_rdy[i-1];
		end
		slot_live[from] = 1'b0;
		slot_dst[from]  = '0;
		slot_rdy[from]  = '0;
	endfunction

	function automatic totals_t predict_totals(logic [FUNC_W-1:0] op, logic [REG_W-1:0] rn,
		logic [STAGE_W-1:0] st, logic [STAGE_W-1:0] fl);
		totals_t r;
		int      hit;
		int      need;
		int      s;
		r    = '0;
		hit  = -1;
		need = 0;
		case (op)
			FUNC_CLOCK: begin
				advance_slots(int'(st));
			end
			FUNC_SRC: begin
				// nearest producer from EXE1 up to MEM2
				for (s = int'(STAGE_EXE1); s < int'(STAGE_WB); s++) begin
					if (hit < 0 && slot_live[s] && slot_dst[s] == rn)
						hit = s;
				end
				if (hit >= 0) begin
					hazard_cnt[hit]++;
					r.hazard_found = 1'b1;
					need = (int'(slot_rdy[hit]) - hit) - (int'(st) - int'(STAGE_ID));
					for (s = 0; s < need; s++) begin
						bubble_cnt++;
						advance_slots(int'(STAGE_EXE1));
					end
					if (need > 0)
						r.bubbles_added = ADD_W'(need);
				end
			end
			FUNC_DEST: begin
				slot_live[STAGE_ID] = 1'b1;
				slot_dst[STAGE_ID]  = rn;
				slot_rdy[STAGE_ID]  = st;
			end
			FUNC_FLUSH: begin
				for (s = 0; s < int'(fl); s++) begin
					flush_cnt++;
					advance_slots(int'(STAGE_IF1));
				end
			end
			default: begin
			end
		endcase
		r.cycle_total  = cycle_cnt;
		r.bubble_total = bubble_cnt;
		r.flush_total  = flush_cnt;
		r.hazard_total = hazard_cnt[st];
		return r;
	endfunction

	function automatic void check_field(string field, logic [CNT_W-1:0] exp_v,
		logic [CNT_W-1:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$error("%s mismatch: expected %0d actual %0d", field, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (k = 0; k < NUM_STAGES; k++) begin
				slot_live[k]  = 1'b0;
				slot_dst[k]   = '0;
				slot_rdy[k]   = '0;
				hazard_cnt[k] = '0;
			end
			cycle_cnt  = CYCLE_RESET;
			bubble_cnt = '0;
			flush_cnt  = '0;
			expected_totals.delete();
			errors  = 0;
		end else begin
			// results first: a result never belongs to a request taken at the same edge
			if (m_tvalid && m_tready) begin
				seen = totals_t'(m_tdata[$bits(totals_t)-1:0]);
				if (expected_totals.size() == 0) begin
					errors++;
					$error("result transaction with nothing expected");
				end else begin
					want = expected_totals.pop_front();
					check_field("cycle_total", want.cycle_total, seen.cycle_total);
					check_field("bubble_total", want.bubble_total, seen.bubble_total);
					check_field("flush_total", want.flush_total, seen.flush_total);
					check_field("hazard_total", want.hazard_total, seen.hazard_total);
					check_field("bubbles_added", CNT_W'(want.bubbles_added),
						CNT_W'(seen.bubbles_added));
					check_field("hazard_found", CNT_W'(want.hazard_found),
						CNT_W'(seen.hazard_found));
				end
			end
			if (s_tvalid && s_tready)
				expected_totals.push_back(predict_totals(s_tuser, s_tdata[REG_W-1:0],
					s_tdata[REG_W +: STAGE_W], s_tdata[REG_W+STAGE_W +: STAGE_W]));
		end
		pending = expected_totals.size();
	end

endmodule

[dv/pipeline_raw_hazard_tracker_tb.sv]
`timescale 1ns / 1ps
// top of the pipeline_raw_hazard_tracker testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict
// depends on rht_pkg, pipeline_raw_hazard_tracker and pipeline_raw_hazard_tracker_checker
module pipeline_raw_hazard_tracker_tb;
	import rht_pkg::*;

	localparam int                TOTAL_ITEMS   = 1350;
	localparam int                QUIET_ITEMS   = 120;
	localparam int                DRAIN_EVERY   = 300;
	localparam int                TAIL_CYCLES   = 16;
	localparam int                STALL_LIMIT   = 1000;
	localparam logic [FUNC_W-1:0] FUNC_MAX      = '1;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [FUNC_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     errors;
	int                     pending;
	int                     sent;
	int                     idle_odds;
	bit                     quiet;

	pipeline_raw_hazard_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pipeline_raw_hazard_tracker_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_op(input logic [FUNC_W-1:0] op, input logic [REG_W-1:0] rn,
		input logic [STAGE_W-1:0] st, input logic [STAGE_W-1:0] fl);
		@(negedge clk);
		if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_TDATA_W'({fl, st, rn});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// result side back-pressure
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("FAIL pipeline_raw_hazard_tracker");
		$finish;
	end

	initial begin
		logic [REG_W-1:0] rn;
		int               op;
		int               next_drain;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = FUNC_CLOCK;
		sent      = 0;
		quiet     = 1'b0;
		idle_odds = 4;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		send_op(FUNC_READ, 5'd0, STAGE_IF1, 3'd0);
		send_op(FUNC_SRC, 5'd0, STAGE_ID, 3'd0);          // empty slots never match
		send_op(FUNC_DEST, 5'd31, STAGE_WB, 3'd7);
		send_op(FUNC_CLOCK, 5'd0, STAGE_ID, 3'd0);
		send_op(FUNC_SRC, 5'd31, STAGE_IF1, 3'd0);        // longest stall
		send_op(FUNC_READ, 5'd0, STAGE_EXE1, 3'd0);
		send_op(FUNC_DEST, 5'd5, STAGE_IF1, 3'd0);
		send_op(FUNC_CLOCK, 5'd0, STAGE_IF1, 3'd0);
		send_op(FUNC_SRC, 5'd5, STAGE_WB, 3'd0);          // negative stall
		send_op(FUNC_DEST, 5'd10, 3'd4, 3'd0);
		send_op(FUNC_CLOCK, 5'd0, STAGE_ID, 3'd0);
		send_op(FUNC_CLOCK, 5'd0, STAGE_ID, 3'd0);
		send_op(FUNC_SRC, 5'd10, STAGE_ID, 3'd0);         // zero stall
		send_op(FUNC_DEST, 5'd0, STAGE_EXE1, 3'd0);
		send_op(FUNC_CLOCK, 5'd31, STAGE_ID, 3'd7);
		send_op(FUNC_SRC, 5'd0, STAGE_IF1, 3'd7);         // live slot holding register zero
		send_op(FUNC_FLUSH, 5'd31, STAGE_WB, 3'd0);
		send_op(FUNC_FLUSH, 5'd0, STAGE_IF1, 3'd7);
		send_op(FUNC_CLOCK, 5'd0, STAGE_WB, 3'd0);
		for (op = int'(FUNC_READ) + 1; op <= int'(FUNC_MAX); op++)
			send_op(FUNC_W'(op), 5'd31, STAGE_WB, 3'd7);
		wait_drained();

		// random: mostly producer, advance, consumer sequences
		next_drain = DRAIN_EVERY;
		while (sent < TOTAL_ITEMS) begin
			if (sent % 100 == 0)
				idle_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 6);
			if (sent >= TOTAL_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			if (sent >= next_drain) begin
				wait_drained();
				next_drain += DRAIN_EVERY;
			end
			if ($urandom_range(0, 99) < 60) begin
				rn = REG_W'($urandom_range(0, 31));
				send_op(FUNC_DEST, rn, STAGE_W'($urandom_range(0, 7)),
					STAGE_W'($urandom_range(0, 7)));
				repeat ($urandom_range(1, 4))
					send_op(FUNC_CLOCK, REG_W'($urandom_range(0, 31)),
						STAGE_W'($urandom_range(0, 2)), STAGE_W'($urandom_range(0, 7)));
				if ($urandom_range(0, 3) == 0)
					rn = REG_W'($urandom_range(0, 31));
				send_op(FUNC_SRC, rn, STAGE_W'($urandom_range(0, 7)),
					STAGE_W'($urandom_range(0, 7)));
			end else begin
				send_op(FUNC_W'($urandom_range(0, int'(FUNC_MAX))),
					REG_W'($urandom_range(0, 31)), STAGE_W'($urandom_range(0, 7)),
					STAGE_W'($urandom_range(0, 7)));
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("PASS pipeline_raw_hazard_tracker");
		else
			$display("FAIL pipeline_raw_hazard_tracker");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/rht_pkg.sv
src/rht_ctrl.sv
src/rht_datapath.sv
src/pipeline_raw_hazard_tracker.sv
dv/pipeline_raw_hazard_tracker_checker.sv
dv/pipeline_raw_hazard_tracker_tb.sv
